// ----- rtl/tcq_pkg.sv -----
// Package: sizes, codes and table entry types of the two-level credit quota block.
package tcq_pkg;

   localparam int DEVICE_COUNT = 16;
   localparam int PATH_COUNT   = 64;
   localparam int SLOT_COUNT   = 64;
   localparam int USAGE_BITS   = 48;

   localparam int DEV_AW  = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;
   localparam int PATH_AW = (PATH_COUNT > 1) ? $clog2(PATH_COUNT) : 1;
   localparam int SLOT_AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   localparam int KIND_W  = 3;
   localparam int DEVF_W  = 4;
   localparam int PATHF_W = 6;
   localparam int CHB_W   = 32;
   localparam int CHW_W   = 16;
   localparam int RID_W   = 7;
   localparam int WRS_W   = 32;
   localparam int STAT_W  = 3;
   localparam int CSR_AW  = 8;

   localparam logic [KIND_W-1:0] KIND_ACQUIRE   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_RELEASE   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SET_DEV   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_CLR_DEV   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_SET_PATH  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_CLR_PATH  = 3'd5;

   localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
   localparam logic [STAT_W-1:0] ST_INVALID   = 3'd1;
   localparam logic [STAT_W-1:0] ST_DEV_FULL  = 3'd2;
   localparam logic [STAT_W-1:0] ST_PATH_FULL = 3'd3;
   localparam logic [STAT_W-1:0] ST_BOTH_FULL = 3'd4;
   localparam logic [STAT_W-1:0] ST_NO_SLOT   = 3'd5;
   localparam logic [STAT_W-1:0] ST_UNKNOWN   = 3'd6;
   localparam logic [STAT_W-1:0] ST_NO_OVR    = 3'd7;

   localparam logic [CSR_AW-1:0] CSR_DEV_BYTES  = 8'd0;
   localparam logic [CSR_AW-1:0] CSR_DEV_WRS    = 8'd1;
   localparam logic [CSR_AW-1:0] CSR_PATH_BYTES = 8'd2;
   localparam logic [CSR_AW-1:0] CSR_PATH_WRS   = 8'd3;

   typedef struct packed {
      logic [USAGE_BITS-1:0] used_bytes;
      logic [WRS_W-1:0]      used_wrs;
      logic [USAGE_BITS-1:0] ovr_bytes;
      logic [WRS_W-1:0]      ovr_wrs;
   } level_entry_type;

   typedef struct packed {
      logic [DEVF_W-1:0]  device;
      logic [PATHF_W-1:0] path;
      logic [CHB_W-1:0]   bytes;
      logic [CHW_W-1:0]   wrs;
   } slot_entry_type;

endpackage

// ----- rtl/tcq_if.sv -----
// Interfaces: request, response and register write channels.
interface tcq_req_if import tcq_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [KIND_W-1:0]         kind;
   logic [DEVF_W-1:0]         device_index;
   logic [PATHF_W-1:0]        path_index;
   logic                      path_valid;
   logic [CHB_W-1:0]          charge_bytes;
   logic [CHW_W-1:0]          charge_wrs;
   logic [RID_W-1:0]          reservation_id;
   logic [USAGE_BITS-1:0]     limit_bytes;
   logic [WRS_W-1:0]          limit_wrs;
   modport source (output valid, kind, device_index, path_index, path_valid, charge_bytes,
                   charge_wrs, reservation_id, limit_bytes, limit_wrs, input ready);
   modport sink (input valid, kind, device_index, path_index, path_valid, charge_bytes,
                 charge_wrs, reservation_id, limit_bytes, limit_wrs, output ready);
endinterface

interface tcq_rsp_if import tcq_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  ok;
   logic [STAT_W-1:0]     status;
   logic [RID_W-1:0]      granted_id;
   logic [USAGE_BITS-1:0] device_bytes_now;
   logic [USAGE_BITS-1:0] path_bytes_now;
   modport source (output valid, ok, status, granted_id, device_bytes_now, path_bytes_now,
                   input ready);
   modport sink (input valid, ok, status, granted_id, device_bytes_now, path_bytes_now,
                 output ready);
endinterface

interface tcq_csr_if import tcq_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_AW-1:0]     index;
   logic [USAGE_BITS-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/tcq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tcq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              we,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
   input  logic [WIDTH-1:0]                  wdata,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
   output logic [WIDTH-1:0]                  rdata_ff
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end
endmodule

// ----- rtl/two_level_credit_quota_top.sv -----
// Top level: two-level credit admission control over device, path and slot tables.
//
//  channel   dir  handshake      payload
//  req_ch    in   valid/ready    kind, indexes, charge, reservation id, override limits
//  rsp_ch    out  valid/ready    ok, status, granted id, device and path byte usage
//  csr_ch    in   valid/ready    register index, write data (always ready)
//
// A request goes through accept and slot table read, device/path table read,
// then compute and write back into the tables and the response register.
// Read-modify-write through registered-read device, path and slot RAMs sets the order.
// Reset clears usage valid bits, override flags and slot busy bits; no clearing pass.
// A response waiting on rsp_ch.ready holds the compute step; requests enter only when idle.
module two_level_credit_quota_top import tcq_pkg::*; (
   input logic clock,
   input logic reset,
   tcq_req_if.sink   req_ch,
   tcq_rsp_if.source rsp_ch,
   tcq_csr_if.sink   csr_ch
);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RD   = 2'd1;
   localparam logic [1:0] S_EXE  = 2'd2;
   localparam logic [USAGE_BITS-1:0] BYTES_CAP = '1;
   localparam logic [WRS_W-1:0]      WRS_CAP   = '1;

   logic [1:0] state_ff, state_in;

   logic [USAGE_BITS-1:0] dev_def_bytes_ff, path_def_bytes_ff;
   logic [WRS_W-1:0]      dev_def_wrs_ff, path_def_wrs_ff;

   logic [KIND_W-1:0]     kind_ff;
   logic [DEVF_W-1:0]     dev_ff;
   logic [PATHF_W-1:0]    path_ff;
   logic                  pvalid_ff;
   logic [CHB_W-1:0]      cbytes_ff;
   logic [CHW_W-1:0]      cwrs_ff;
   logic [RID_W-1:0]      rid_ff;
   logic [USAGE_BITS-1:0] lbytes_ff;
   logic [WRS_W-1:0]      lwrs_ff;

   logic [DEVICE_COUNT-1:0] dev_uv_ff, dev_ovr_ff;
   logic [PATH_COUNT-1:0]   path_uv_ff, path_ovr_ff;
   logic [SLOT_COUNT-1:0]   busy_ff;
   logic [SLOT_AW-1:0]      free_idx_ff, free_idx_in;
   logic                    free_any_ff, free_any_in;

   slot_entry_type        slot_rd, slot_ff;
   logic                  rel_hit_ff;
   logic [DEV_AW-1:0]     sel_dev_ff;
   logic [PATH_AW-1:0]    sel_path_ff;
   logic                  rdev_ok_ff, rpath_ok_ff;
   level_entry_type       dev_rd, path_rd, dev_wr, path_wr;

   logic                  rsp_valid_ff, rsp_ok_ff;
   logic [STAT_W-1:0]     rsp_status_ff;
   logic [RID_W-1:0]      rsp_gid_ff;
   logic [USAGE_BITS-1:0] rsp_dbytes_ff, rsp_pbytes_ff;

   logic                  req_fire, exe_go;
   logic [RID_W-1:0]      rid_m1;
   logic                  rid_in_range;
   logic                  rel_hit;
   logic [SLOT_AW-1:0]    rel_idx;
   logic [DEV_AW-1:0]     dev_raddr, dev_ram_raddr;
   logic [PATH_AW-1:0]    path_raddr, path_ram_raddr;

   logic [USAGE_BITS-1:0] d_ub, p_ub, d_lb, p_lb;
   logic [WRS_W-1:0]      d_uw, p_uw, d_lw, p_lw;
   logic                  dfit, pfit, acq_ok, grant, rel_ok, dev_wr_en, path_wr_en;
   logic [STAT_W-1:0]     status;
   logic [USAGE_BITS:0]   d_bsum, p_bsum;
   logic [WRS_W:0]        d_wsum, p_wsum;
   logic [USAGE_BITS-1:0] cb_ext;
   logic [WRS_W-1:0]      cw_ext, s_cw_ext;
   logic [USAGE_BITS-1:0] s_cb_ext;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;
   assign exe_go = (state_ff == S_EXE) && (!rsp_valid_ff || rsp_ch.ready);

   assign rid_m1  = req_ch.reservation_id - RID_W'(1);
   assign rel_idx = rid_ff[SLOT_AW-1:0] - SLOT_AW'(1);
   assign rid_in_range = (rid_ff != '0) && (32'(rid_ff) <= SLOT_COUNT);
   assign rel_hit = (kind_ff == KIND_RELEASE) && rid_in_range && busy_ff[rel_idx];

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dev_def_bytes_ff  <= '1;
         dev_def_wrs_ff    <= '1;
         path_def_bytes_ff <= '1;
         path_def_wrs_ff   <= '1;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_DEV_BYTES:  dev_def_bytes_ff  <= csr_ch.data;
            CSR_DEV_WRS:    dev_def_wrs_ff    <= csr_ch.data[WRS_W-1:0];
            CSR_PATH_BYTES: path_def_bytes_ff <= csr_ch.data;
            CSR_PATH_WRS:   path_def_wrs_ff   <= csr_ch.data[WRS_W-1:0];
            default: ;
         endcase
      end
   end

   // Capture the request
   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff   <= req_ch.kind;
         dev_ff    <= req_ch.device_index;
         path_ff   <= req_ch.path_index;
         pvalid_ff <= req_ch.path_valid;
         cbytes_ff <= req_ch.charge_bytes;
         cwrs_ff   <= req_ch.charge_wrs;
         rid_ff    <= req_ch.reservation_id;
         lbytes_ff <= req_ch.limit_bytes;
         lwrs_ff   <= req_ch.limit_wrs;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_fire) state_in = S_RD;
         S_RD:    state_in = S_EXE;
         S_EXE:   if (exe_go) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   // Lowest free slot, registered; settles well before the next compute step
   always_comb begin
      free_idx_in = '0;
      free_any_in = 1'b0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            free_idx_in = SLOT_AW'(i);
            free_any_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      free_idx_ff <= free_idx_in;
      free_any_ff <= free_any_in;
   end

   // Slot table read, then pick the device and path to read
   tcq_ram #(.WIDTH($bits(slot_entry_type)), .DEPTH(SLOT_COUNT)) u_slot_ram (
      .clock    (clock),
      .we       (exe_go && grant),
      .waddr    (free_idx_ff),
      .wdata    ({dev_ff, path_ff, cbytes_ff, cwrs_ff}),
      .raddr    (rid_m1[SLOT_AW-1:0]),
      .rdata_ff (slot_rd)
   );

   // A release that misses reports the request's own device and path
   assign dev_raddr  = rel_hit ? DEV_AW'(slot_rd.device) : DEV_AW'(dev_ff);
   assign path_raddr = rel_hit ? PATH_AW'(slot_rd.path) : PATH_AW'(path_ff);

   // Hold the table read address while the compute step waits
   assign dev_ram_raddr  = (state_ff == S_RD) ? dev_raddr : sel_dev_ff;
   assign path_ram_raddr = (state_ff == S_RD) ? path_raddr : sel_path_ff;

   always_ff @(posedge clock) begin
      if (state_ff == S_RD) begin
         slot_ff     <= slot_rd;
         sel_dev_ff  <= dev_raddr;
         sel_path_ff <= path_raddr;
         rel_hit_ff  <= rel_hit;
         rdev_ok_ff  <= (kind_ff == KIND_RELEASE) || (32'(dev_ff) < DEVICE_COUNT);
         rpath_ok_ff <= (kind_ff == KIND_RELEASE) || (32'(path_ff) < PATH_COUNT);
      end
   end

   tcq_ram #(.WIDTH($bits(level_entry_type)), .DEPTH(DEVICE_COUNT)) u_dev_ram (
      .clock    (clock),
      .we       (exe_go && dev_wr_en),
      .waddr    (sel_dev_ff),
      .wdata    (dev_wr),
      .raddr    (dev_ram_raddr),
      .rdata_ff (dev_rd)
   );

   tcq_ram #(.WIDTH($bits(level_entry_type)), .DEPTH(PATH_COUNT)) u_path_ram (
      .clock    (clock),
      .we       (exe_go && path_wr_en),
      .waddr    (sel_path_ff),
      .wdata    (path_wr),
      .raddr    (path_ram_raddr),
      .rdata_ff (path_rd)
   );

   // Compute: limits, fit checks, new usages
   always_comb begin
      d_ub = dev_uv_ff[sel_dev_ff] ? dev_rd.used_bytes : '0;
      d_uw = dev_uv_ff[sel_dev_ff] ? dev_rd.used_wrs : '0;
      p_ub = path_uv_ff[sel_path_ff] ? path_rd.used_bytes : '0;
      p_uw = path_uv_ff[sel_path_ff] ? path_rd.used_wrs : '0;
      d_lb = dev_ovr_ff[sel_dev_ff] ? dev_rd.ovr_bytes : dev_def_bytes_ff;
      d_lw = dev_ovr_ff[sel_dev_ff] ? dev_rd.ovr_wrs : dev_def_wrs_ff;
      p_lb = path_ovr_ff[sel_path_ff] ? path_rd.ovr_bytes : path_def_bytes_ff;
      p_lw = path_ovr_ff[sel_path_ff] ? path_rd.ovr_wrs : path_def_wrs_ff;
      cb_ext   = USAGE_BITS'(cbytes_ff);
      cw_ext   = WRS_W'(cwrs_ff);
      s_cb_ext = USAGE_BITS'(slot_ff.bytes);
      s_cw_ext = WRS_W'(slot_ff.wrs);

      dfit = (d_ub <= d_lb) && (cb_ext <= d_lb - d_ub) &&
             (d_uw <= d_lw) && (cw_ext <= d_lw - d_uw);
      pfit = (p_ub <= p_lb) && (cb_ext <= p_lb - p_ub) &&
             (p_uw <= p_lw) && (cw_ext <= p_lw - p_uw);
      d_bsum = {1'b0, d_ub} + {1'b0, cb_ext};
      p_bsum = {1'b0, p_ub} + {1'b0, cb_ext};
      d_wsum = {1'b0, d_uw} + {1'b0, cw_ext};
      p_wsum = {1'b0, p_uw} + {1'b0, cw_ext};

      acq_ok = pvalid_ff && (cwrs_ff != '0) && (32'(dev_ff) < DEVICE_COUNT) &&
               (32'(path_ff) < PATH_COUNT);
      grant  = 1'b0;
      rel_ok = 1'b0;
      dev_wr_en  = 1'b0;
      path_wr_en = 1'b0;
      status = ST_INVALID;

      dev_wr  = dev_rd;
      path_wr = path_rd;
      dev_wr.used_bytes  = d_ub;
      dev_wr.used_wrs    = d_uw;
      path_wr.used_bytes = p_ub;
      path_wr.used_wrs   = p_uw;

      unique case (kind_ff)
         KIND_ACQUIRE: begin
            if (acq_ok) begin
               if (!dfit && !pfit) status = ST_BOTH_FULL;
               else if (!dfit) status = ST_DEV_FULL;
               else if (!pfit) status = ST_PATH_FULL;
               else if (!free_any_ff) status = ST_NO_SLOT;
               else begin
                  status = ST_OK;
                  grant  = 1'b1;
               end
            end
            if (grant) begin
               dev_wr.used_bytes  = d_bsum[USAGE_BITS] ? BYTES_CAP : d_bsum[USAGE_BITS-1:0];
               dev_wr.used_wrs    = d_wsum[WRS_W] ? WRS_CAP : d_wsum[WRS_W-1:0];
               path_wr.used_bytes = p_bsum[USAGE_BITS] ? BYTES_CAP : p_bsum[USAGE_BITS-1:0];
               path_wr.used_wrs   = p_wsum[WRS_W] ? WRS_CAP : p_wsum[WRS_W-1:0];
               dev_wr_en  = 1'b1;
               path_wr_en = 1'b1;
            end
         end
         KIND_RELEASE: begin
            status = ST_UNKNOWN;
            if (rel_hit_ff) begin
               status = ST_OK;
               rel_ok = 1'b1;
               dev_wr.used_bytes  = (s_cb_ext >= d_ub) ? '0 : d_ub - s_cb_ext;
               dev_wr.used_wrs    = (s_cw_ext >= d_uw) ? '0 : d_uw - s_cw_ext;
               path_wr.used_bytes = (s_cb_ext >= p_ub) ? '0 : p_ub - s_cb_ext;
               path_wr.used_wrs   = (s_cw_ext >= p_uw) ? '0 : p_uw - s_cw_ext;
               dev_wr_en  = 1'b1;
               path_wr_en = 1'b1;
            end
         end
         KIND_SET_DEV: begin
            if (32'(dev_ff) < DEVICE_COUNT) begin
               status = ST_OK;
               dev_wr.ovr_bytes = lbytes_ff;
               dev_wr.ovr_wrs   = lwrs_ff;
               dev_wr_en = 1'b1;
            end
         end
         KIND_CLR_DEV: begin
            if (32'(dev_ff) < DEVICE_COUNT) begin
               status = dev_ovr_ff[sel_dev_ff] ? ST_OK : ST_NO_OVR;
            end
         end
         KIND_SET_PATH: begin
            if (pvalid_ff && (32'(path_ff) < PATH_COUNT)) begin
               status = ST_OK;
               path_wr.ovr_bytes = lbytes_ff;
               path_wr.ovr_wrs   = lwrs_ff;
               path_wr_en = 1'b1;
            end
         end
         KIND_CLR_PATH: begin
            if (pvalid_ff && (32'(path_ff) < PATH_COUNT)) begin
               status = path_ovr_ff[sel_path_ff] ? ST_OK : ST_NO_OVR;
            end
         end
         default: status = ST_INVALID;
      endcase
   end

   // Flags and valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         dev_uv_ff   <= '0;
         path_uv_ff  <= '0;
         dev_ovr_ff  <= '0;
         path_ovr_ff <= '0;
         busy_ff     <= '0;
      end else if (exe_go) begin
         if (dev_wr_en) dev_uv_ff[sel_dev_ff] <= 1'b1;
         if (path_wr_en) path_uv_ff[sel_path_ff] <= 1'b1;
         if (grant) busy_ff[free_idx_ff] <= 1'b1;
         if (rel_ok) busy_ff[rel_idx] <= 1'b0;
         if (kind_ff == KIND_SET_DEV && status == ST_OK) dev_ovr_ff[sel_dev_ff] <= 1'b1;
         if (kind_ff == KIND_CLR_DEV && status == ST_OK) dev_ovr_ff[sel_dev_ff] <= 1'b0;
         if (kind_ff == KIND_SET_PATH && status == ST_OK) path_ovr_ff[sel_path_ff] <= 1'b1;
         if (kind_ff == KIND_CLR_PATH && status == ST_OK) path_ovr_ff[sel_path_ff] <= 1'b0;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exe_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exe_go) begin
         rsp_ok_ff     <= (status == ST_OK);
         rsp_status_ff <= status;
         rsp_gid_ff    <= grant ? RID_W'(free_idx_ff) + RID_W'(1) : '0;
         rsp_dbytes_ff <= rdev_ok_ff ? dev_wr.used_bytes : '0;
         rsp_pbytes_ff <= rpath_ok_ff ? path_wr.used_bytes : '0;
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.ok               = rsp_ok_ff;
   assign rsp_ch.status           = rsp_status_ff;
   assign rsp_ch.granted_id       = rsp_gid_ff;
   assign rsp_ch.device_bytes_now = rsp_dbytes_ff;
   assign rsp_ch.path_bytes_now   = rsp_pbytes_ff;

   a_rsp_from_exe: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EXE))
      else $error("response raised outside the compute step");

   a_grant_sets_busy: assert property (@(posedge clock) disable iff (reset)
      (exe_go && grant) |=> busy_ff[$past(free_idx_ff)])
      else $error("granted slot not marked busy");

   a_busy_step: assert property (@(posedge clock) disable iff (reset)
      $countones(busy_ff) <= $past($countones(busy_ff)) + 1)
      else $error("more than one slot taken in a cycle");

   a_gid_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_gid_ff != '0) |-> (rsp_ok_ff && rsp_status_ff == ST_OK))
      else $error("granted id on a failed request");
endmodule
